// File: design/sis_pkg.sv
// sis_pkg: shared constants, result codes and control structs of the sorter
// used by sis_ctrl, sis_datapath and stack_insertion_sorter; no dependencies

package sis_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // request kinds carried on in_tuser
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  // result status codes carried on out_tuser
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ELEMENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic                insert;     // place new value into the cell row
    logic                rotate;     // rotate the occupied cells by one
    logic                load_out;   // capture a result into the output register
    logic                pass_cell;  // result value is cell 0, else zero
    logic [STATUS_W-1:0] status;
    logic                last;
  } sis_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } sis_stat_t;

endpackage

// File: design/sis_datapath.sv
// sis_datapath: row of sorted value cells with parallel compare, shift-insert
// and readout rotation, plus the output result register; uses sis_pkg

module sis_datapath import sis_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sis_cmd_t            cmd,
  input  logic [VALUE_W-1:0]  new_value,
  output sis_stat_t           stat,
  output logic [CNT_W-1:0]    count,
  output logic [VALUE_W-1:0]  res_value,
  output logic [STATUS_W-1:0] res_status,
  output logic                res_last,
  output logic [FILL_W-1:0]   res_fill
);

  logic [VALUE_W-1:0] cells_r [DEPTH];
  logic [VALUE_W-1:0] cells_nxt [DEPTH];
  logic [DEPTH-1:0]   lt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W+FILL_W-1:0] count_ext;

  logic [VALUE_W-1:0]  res_value_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                res_last_r;
  logic [FILL_W-1:0]   res_fill_r;

  // per cell: occupied and strictly smaller than the new value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign lt[i] = (CNT_W'(i) < count_r) &&
                   ($signed(cells_r[i]) < $signed(new_value));

    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (cmd.insert) begin
        if (!lt[i]) begin
          if (i == 0) begin
            cells_nxt[i] = new_value;
          end else if (lt[(i == 0) ? 0 : i-1]) begin
            cells_nxt[i] = new_value;
          end else begin
            cells_nxt[i] = cells_r[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.rotate) begin
        if (CNT_W'(i + 1) == count_r) begin
          cells_nxt[i] = cells_r[0];
        end else if (CNT_W'(i + 1) < count_r) begin
          cells_nxt[i] = cells_r[(i == DEPTH-1) ? i : i+1];
        end
      end
    end

    always_ff @(posedge clk) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  assign count_nxt = cmd.insert ? count_r + CNT_W'(1) : count_r;
  assign count_ext = (CNT_W+FILL_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_value_r  <= cmd.pass_cell ? cells_r[0] : '0;
      res_status_r <= cmd.status;
      res_last_r   <= cmd.last;
      res_fill_r   <= count_ext[FILL_W-1:0];
    end
  end

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign count      = count_r;
  assign res_value  = res_value_r;
  assign res_status = res_status_r;
  assign res_last   = res_last_r;
  assign res_fill   = res_fill_r;

endmodule

// File: design/sis_ctrl.sv
// sis_ctrl: request sequencer and output valid tracking for the sorter
// uses sis_pkg; drives sis_datapath through sis_cmd_t

module sis_ctrl import sis_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req,
  output logic             out_valid,
  input  logic             out_ready,
  input  sis_stat_t        stat,
  input  logic [CNT_W-1:0] count,
  output sis_cmd_t         cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;
  logic             take;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign take      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_req == REQ_INSERT) begin
            cmd.insert   = !stat.full;
            cmd.load_out = 1'b1;
            cmd.status   = stat.full ? ST_FULL : ST_INSERTED;
            cmd.last     = 1'b1;
          end else if (stat.empty) begin
            cmd.load_out = 1'b1;
            cmd.status   = ST_EMPTY;
            cmd.last     = 1'b1;
          end else begin
            left_nxt  = count;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.pass_cell = 1'b1;
          cmd.rotate    = 1'b1;
          cmd.status    = ST_ELEMENT;
          cmd.last      = (left_r == CNT_W'(1));
          left_nxt      = left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/stack_insertion_sorter.sv
// stack_insertion_sorter: top level of the bounded ascending-order value store
// instantiates sis_ctrl and sis_datapath; uses sis_pkg
//
//  channel | direction | tdata                                   | tuser       | tlast
//  in_     | slave     | [31:0] new_value                        | req_type    | -
//  out_    | master    | [31:0] out_value, [36:32] fill_count    | status[1:0] | last
//
// an insert into a non-full row compares every cell against the new value at once
// and the row shifts up from the insertion point, together with the result load
// a readout of n values gives one value per cycle out of cell 0 unless the output
// stalls, while the occupied cells rotate back to their original order
// the output register holds a result until it is taken; a stalled output stalls
// the readout rotation and the next input transfer
// rst_n clears the fill count and control; cell contents need no reset

module stack_insertion_sorter import sis_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] new_value
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] out_value, [36:32] fill_count, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last result of the request
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  sis_cmd_t            cmd;
  sis_stat_t           stat;
  logic [CNT_W-1:0]    count;
  logic [VALUE_W-1:0]  res_value;
  logic [STATUS_W-1:0] res_status;
  logic                res_last;
  logic [FILL_W-1:0]   res_fill;

  // sequencing of inserts and readouts
  sis_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .count     (count),
    .cmd       (cmd)
  );

  // cell row and result register
  sis_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .new_value  (in_tdata),
    .stat       (stat),
    .count      (count),
    .res_value  (res_value),
    .res_status (res_status),
    .res_last   (res_last),
    .res_fill   (res_fill)
  );

  // pack the result transfer
  assign out_tdata = {3'b000, res_fill, res_value};
  assign out_tuser = res_status;
  assign out_tlast = res_last;

endmodule
